@@ hw/rtl/ctt_pkg.sv @@
package ctt_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int MAX_FIRED = 32;
    localparam int FIRE_W    = $clog2(MAX_FIRED + 1);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_SERVICE = 2'd2,
        OP_REARM   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_FIRED  = 3'd2,
        KIND_END    = 3'd3,
        KIND_REARM  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_REARM_RD,
        ST_REARM_EV
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_GE
    } alu_op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] now_ms;
        logic [31:0] interval;
        logic [31:0] timer_id;
        logic [4:0]  slot;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [31:0] id_out;
        logic [4:0]  slot_out;
        logic [31:0] interval_out;
        logic        last;
    } rsp_t;

endpackage

@@ hw/rtl/ctt_alu.sv @@
module ctt_alu
(
    input  ctt_pkg::alu_op_t op,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    output logic [63:0]      sum,
    output logic             ge
);

    logic [63:0] b_eff;
    logic [64:0] total;

    // A compare is a subtraction: a carry out means a is not below b.
    assign b_eff = (op == ctt_pkg::ALU_GE) ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_eff} + 65'((op == ctt_pkg::ALU_GE) ? 1 : 0);
    assign sum   = total[63:0];
    assign ge    = total[64];

endmodule

@@ hw/rtl/callback_timer_table.sv @@
// Rearm reads the addressed slot in ST_REARM_RD and evaluates it in ST_REARM_EV, which
// registers the final result. Add and remove scan the slots in order and stop at the first free
// or matching slot or after the last slot; service scans every slot, then ends in ST_FINISH.
// The scan reads the slot memories at one slot per cycle; busy is high meanwhile,
// and a new transaction may start in the cycle the final result appears.
// Reset clears the live and pending bits and sets the id counter to one; results cannot be stalled.
module callback_timer_table
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ctt_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    output ctt_pkg::rsp_t   rsp
);

    ctt_pkg::state_t state_reg, state_next;
    ctt_pkg::cmd_t   in_reg, in_next;
    logic [ctt_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       ev_vld_reg, ev_vld_next;
    logic [ctt_pkg::SLOT_W-1:0] ev_idx_reg, ev_idx_next;
    logic [ctt_pkg::FIRE_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic [ctt_pkg::SLOTS-1:0]  live_reg, live_next;
    logic [ctt_pkg::SLOTS-1:0]  pend_reg, pend_next;
    logic [31:0]                next_id_reg, next_id_next;
    ctt_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic [31:0] ident_mem [ctt_pkg::SLOTS];
    logic [31:0] period_mem [ctt_pkg::SLOTS];
    logic [63:0] deadline_mem [ctt_pkg::SLOTS];
    logic [31:0] ident_rd_reg;
    logic [31:0] period_rd_reg;
    logic [63:0] deadline_rd_reg;

    logic [ctt_pkg::SLOT_W-1:0] rd_addr;
    logic [ctt_pkg::SLOT_W-1:0] wr_addr;
    logic                       wr_ident_en;
    logic                       wr_time_en;
    logic [31:0]                wr_ident;

    ctt_pkg::alu_op_t alu_op;
    logic [63:0]      alu_b;
    logic [63:0]      alu_sum;
    logic             alu_ge;

    logic                       scan_stop;
    logic                       last_slot;
    logic [31:0]                id_assign;
    logic [ctt_pkg::SLOT_W-1:0] rearm_idx;
    logic                       rearm_slot_ok;
    logic                       rearm_match;

    assign busy      = (state_reg != ctt_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign last_slot     = (ev_idx_reg == ctt_pkg::SLOT_W'(ctt_pkg::SLOTS - 1));
    assign id_assign     = (next_id_reg == 32'd0) ? 32'd1 : next_id_reg;
    assign rearm_idx     = ctt_pkg::SLOT_W'(in_reg.slot);
    assign rearm_slot_ok = (32'(in_reg.slot) < 32'(ctt_pkg::SLOTS));
    assign rearm_match   = rearm_slot_ok && (in_reg.timer_id != 32'd0) &&
                           live_reg[rearm_idx] && (ident_rd_reg == in_reg.timer_id);

    assign alu_op = (in_reg.op == ctt_pkg::OP_SERVICE) ? ctt_pkg::ALU_GE : ctt_pkg::ALU_ADD;
    assign alu_b  = (in_reg.op == ctt_pkg::OP_SERVICE) ? deadline_rd_reg
                                                       : {32'd0, in_reg.interval};

    ctt_alu u_alu
    (
        .op  (alu_op),
        .a   (in_reg.now_ms),
        .b   (alu_b),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.op == ctt_pkg::OP_REARM) ? ctt_pkg::ST_REARM_RD
                                                               : ctt_pkg::ST_SCAN;
                end
            end
            ctt_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = (in_reg.op == ctt_pkg::OP_SERVICE) ? ctt_pkg::ST_FINISH
                                                                    : ctt_pkg::ST_IDLE;
                end
            end
            ctt_pkg::ST_FINISH:   state_next = ctt_pkg::ST_IDLE;
            ctt_pkg::ST_REARM_RD: state_next = ctt_pkg::ST_REARM_EV;
            ctt_pkg::ST_REARM_EV: state_next = ctt_pkg::ST_IDLE;
            default:              state_next = ctt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_next        = in_reg;
        idx_next       = idx_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = ev_idx_reg;
        fire_cnt_next  = fire_cnt_reg;
        live_next      = live_reg;
        pend_next      = pend_reg;
        next_id_next   = next_id_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = 1'b0;
        rd_addr        = idx_reg[ctt_pkg::SLOT_W-1:0];
        wr_addr        = ev_idx_reg;
        wr_ident_en    = 1'b0;
        wr_time_en     = 1'b0;
        wr_ident       = id_assign;
        scan_stop      = 1'b0;

        case (state_reg)
            ctt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    in_next       = cmd;
                    idx_next      = '0;
                    fire_cnt_next = '0;
                end
            end
            ctt_pkg::ST_SCAN:
            begin
                if (ev_vld_reg)
                begin
                    case (in_reg.op)
                        ctt_pkg::OP_ADD:
                        begin
                            if (!live_reg[ev_idx_reg])
                            begin
                                wr_ident_en           = 1'b1;
                                wr_time_en            = 1'b1;
                                live_next[ev_idx_reg] = 1'b1;
                                pend_next[ev_idx_reg] = 1'b0;
                                next_id_next          = id_assign + 32'd1;
                                rsp_valid_next        = 1'b1;
                                rsp_next              = '0;
                                rsp_next.kind         = ctt_pkg::KIND_ADD;
                                rsp_next.ok           = 1'b1;
                                rsp_next.id_out       = id_assign;
                                rsp_next.slot_out     = 5'(ev_idx_reg);
                                rsp_next.interval_out = in_reg.interval;
                                rsp_next.last         = 1'b1;
                                scan_stop             = 1'b1;
                            end
                            else if (last_slot)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '0;
                                rsp_next.kind  = ctt_pkg::KIND_ADD;
                                rsp_next.last  = 1'b1;
                                scan_stop      = 1'b1;
                            end
                        end
                        ctt_pkg::OP_REMOVE:
                        begin
                            if ((in_reg.timer_id != 32'd0) && live_reg[ev_idx_reg] &&
                                (ident_rd_reg == in_reg.timer_id))
                            begin
                                live_next[ev_idx_reg] = 1'b0;
                                pend_next[ev_idx_reg] = 1'b0;
                                rsp_valid_next        = 1'b1;
                                rsp_next              = '0;
                                rsp_next.kind         = ctt_pkg::KIND_REMOVE;
                                rsp_next.ok           = 1'b1;
                                rsp_next.id_out       = in_reg.timer_id;
                                rsp_next.slot_out     = 5'(ev_idx_reg);
                                rsp_next.last         = 1'b1;
                                scan_stop             = 1'b1;
                            end
                            else if (last_slot)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next        = '0;
                                rsp_next.kind   = ctt_pkg::KIND_REMOVE;
                                rsp_next.id_out = in_reg.timer_id;
                                rsp_next.last   = 1'b1;
                                scan_stop       = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (live_reg[ev_idx_reg] && !pend_reg[ev_idx_reg] && alu_ge &&
                                (fire_cnt_reg < ctt_pkg::FIRE_W'(ctt_pkg::MAX_FIRED)))
                            begin
                                pend_next[ev_idx_reg] = 1'b1;
                                fire_cnt_next         = fire_cnt_reg + 1'b1;
                                rsp_valid_next        = 1'b1;
                                rsp_next              = '0;
                                rsp_next.kind         = ctt_pkg::KIND_FIRED;
                                rsp_next.ok           = 1'b1;
                                rsp_next.id_out       = ident_rd_reg;
                                rsp_next.slot_out     = 5'(ev_idx_reg);
                                rsp_next.interval_out = period_rd_reg;
                            end
                            scan_stop = last_slot;
                        end
                    endcase
                end

                if (!scan_stop && (idx_reg < ctt_pkg::CNT_W'(ctt_pkg::SLOTS)))
                begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = idx_reg[ctt_pkg::SLOT_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
            end
            ctt_pkg::ST_FINISH:
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '0;
                rsp_next.kind  = ctt_pkg::KIND_END;
                rsp_next.ok    = 1'b1;
                rsp_next.last  = 1'b1;
            end
            ctt_pkg::ST_REARM_RD:
            begin
                rd_addr = rearm_idx;
            end
            ctt_pkg::ST_REARM_EV:
            begin
                wr_addr = rearm_idx;
                if (rearm_match)
                begin
                    if (in_reg.interval == 32'd0)
                    begin
                        live_next[rearm_idx] = 1'b0;
                    end
                    else
                    begin
                        wr_time_en = 1'b1;
                    end
                    pend_next[rearm_idx] = 1'b0;
                end
                rsp_valid_next        = 1'b1;
                rsp_next.kind         = ctt_pkg::KIND_REARM;
                rsp_next.ok           = rearm_match;
                rsp_next.id_out       = in_reg.timer_id;
                rsp_next.slot_out     = in_reg.slot;
                rsp_next.interval_out = in_reg.interval;
                rsp_next.last         = 1'b1;
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ident_rd_reg    <= ident_mem[rd_addr];
        period_rd_reg   <= period_mem[rd_addr];
        deadline_rd_reg <= deadline_mem[rd_addr];
        if (wr_ident_en)
        begin
            ident_mem[wr_addr] <= wr_ident;
        end
        if (wr_time_en)
        begin
            period_mem[wr_addr]   <= in_reg.interval;
            deadline_mem[wr_addr] <= alu_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctt_pkg::ST_IDLE;
            ev_vld_reg    <= 1'b0;
            live_reg      <= '0;
            pend_reg      <= '0;
            next_id_reg   <= 32'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ev_vld_reg    <= ev_vld_next;
            live_reg      <= live_next;
            pend_reg      <= pend_next;
            next_id_reg   <= next_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        idx_reg      <= idx_next;
        ev_idx_reg   <= ev_idx_next;
        fire_cnt_reg <= fire_cnt_next;
        rsp_reg      <= rsp_next;
    end

    // The block goes idle only together with the final result of a transaction.
    a_idle_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (rsp_valid && rsp.last))
        else $error("busy fell without a final result");

    a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |-> !busy)
        else $error("final result while still busy");

    a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ~live_reg) == '0)
        else $error("pending bit set on a free slot");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> (state_reg == ctt_pkg::ST_SCAN))
        else $error("slot evaluation outside a scan");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int PLAN_ITEMS     = 350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum int {
        PICK_LIVE,
        PICK_FREE,
        PICK_FIRED,
        PICK_ARMED
    } slot_pick_t;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    ctt_pkg::cmd_t cmd   = '0;
    logic          rsp_valid;
    ctt_pkg::rsp_t rsp;

    callback_timer_table i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the timer table, updated when a command transaction is taken.
    logic [31:0] tbl_ident    [ctt_pkg::SLOTS];
    logic [31:0] tbl_period   [ctt_pkg::SLOTS];
    logic [63:0] tbl_deadline [ctt_pkg::SLOTS];
    logic        tbl_pending  [ctt_pkg::SLOTS];
    logic [31:0] tbl_next_id;

    ctt_pkg::cmd_t cmd_backlog  [$];
    ctt_pkg::rsp_t rsp_forecast [$];

    int            err_count    = 0;
    int            plan_count   = 0;
    int            gap_left     = 0;
    int            launches     = 0;
    bit            no_idle      = 1'b0;
    int            quiet_cycles = 0;
    logic [63:0]   gen_now      = 64'd1000;
    ctt_pkg::rsp_t rsp_want;

    initial
    begin
        for (int i = 0; i < ctt_pkg::SLOTS; i++)
        begin
            tbl_ident[i]    = '0;
            tbl_period[i]   = '0;
            tbl_deadline[i] = '0;
            tbl_pending[i]  = 1'b0;
        end
        tbl_next_id = 32'd1;
    end

    task automatic push_rsp(ctt_pkg::kind_t kind, logic ok, logic [31:0] id, logic [4:0] sl,
                            logic [31:0] ival, logic last);
        ctt_pkg::rsp_t r;
        r.kind         = kind;
        r.ok           = ok;
        r.id_out       = id;
        r.slot_out     = sl;
        r.interval_out = ival;
        r.last         = last;
        rsp_forecast.push_back(r);
    endtask

    task automatic apply_timer_cmd(ctt_pkg::cmd_t c);
        logic found;
        int   n;
        found = 1'b0;
        n     = 0;
        case (c.op)
            ctt_pkg::OP_ADD:
            begin
                for (int i = 0; i < ctt_pkg::SLOTS && !found; i++)
                begin
                    if (tbl_ident[i] == 32'd0)
                    begin
                        if (tbl_next_id == 32'd0)
                        begin
                            tbl_next_id = 32'd1;
                        end
                        tbl_ident[i]    = tbl_next_id;
                        tbl_period[i]   = c.interval;
                        tbl_deadline[i] = c.now_ms + {32'd0, c.interval};
                        tbl_pending[i]  = 1'b0;
                        push_rsp(ctt_pkg::KIND_ADD, 1'b1, tbl_next_id, 5'(i),
                                 c.interval, 1'b1);
                        tbl_next_id = tbl_next_id + 32'd1;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    push_rsp(ctt_pkg::KIND_ADD, 1'b0, 32'd0, 5'd0, 32'd0, 1'b1);
                end
            end
            ctt_pkg::OP_REMOVE:
            begin
                if (c.timer_id != 32'd0)
                begin
                    for (int i = 0; i < ctt_pkg::SLOTS && !found; i++)
                    begin
                        if (tbl_ident[i] == c.timer_id)
                        begin
                            tbl_ident[i]   = 32'd0;
                            tbl_pending[i] = 1'b0;
                            push_rsp(ctt_pkg::KIND_REMOVE, 1'b1, c.timer_id, 5'(i),
                                     32'd0, 1'b1);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    push_rsp(ctt_pkg::KIND_REMOVE, 1'b0, c.timer_id, 5'd0, 32'd0, 1'b1);
                end
            end
            ctt_pkg::OP_SERVICE:
            begin
                for (int i = 0; i < ctt_pkg::SLOTS; i++)
                begin
                    if (n < ctt_pkg::MAX_FIRED && tbl_ident[i] != 32'd0 && !tbl_pending[i] &&
                        c.now_ms >= tbl_deadline[i])
                    begin
                        tbl_pending[i] = 1'b1;
                        push_rsp(ctt_pkg::KIND_FIRED, 1'b1, tbl_ident[i], 5'(i),
                                 tbl_period[i], 1'b0);
                        n++;
                    end
                end
                push_rsp(ctt_pkg::KIND_END, 1'b1, 32'd0, 5'd0, 32'd0, 1'b1);
            end
            default:
            begin
                if (int'(c.slot) < ctt_pkg::SLOTS && c.timer_id != 32'd0 &&
                    tbl_ident[c.slot] == c.timer_id)
                begin
                    if (c.interval == 32'd0)
                    begin
                        tbl_ident[c.slot] = 32'd0;
                    end
                    else
                    begin
                        tbl_period[c.slot]   = c.interval;
                        tbl_deadline[c.slot] = c.now_ms + {32'd0, c.interval};
                    end
                    tbl_pending[c.slot] = 1'b0;
                    push_rsp(ctt_pkg::KIND_REARM, 1'b1, c.timer_id, c.slot, c.interval, 1'b1);
                end
                else
                begin
                    push_rsp(ctt_pkg::KIND_REARM, 1'b0, c.timer_id, c.slot, c.interval, 1'b1);
                end
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_timer_cmd(cmd);
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd      <= cmd_backlog.pop_front();
                    start    <= 1'b1;
                    gap_left = pick_gap();
                    launches++;
                    if (launches % 25 == 0)
                    begin
                        no_idle = ($urandom_range(0, 2) == 0);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid)
        begin
            if (rsp_forecast.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
                err_count++;
            end
            else
            begin
                rsp_want = rsp_forecast.pop_front();
                check_field("kind", 32'(rsp_want.kind), 32'(rsp.kind));
                check_field("ok", 32'(rsp_want.ok), 32'(rsp.ok));
                check_field("id_out", rsp_want.id_out, rsp.id_out);
                check_field("slot_out", 32'(rsp_want.slot_out), 32'(rsp.slot_out));
                check_field("interval_out", rsp_want.interval_out, rsp.interval_out);
                check_field("last", 32'(rsp_want.last), 32'(rsp.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || rsp_valid)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_cmd(ctt_pkg::op_t op, logic [63:0] now, logic [31:0] ival,
                             logic [31:0] tid, logic [4:0] sl);
        ctt_pkg::cmd_t c;
        c.op       = op;
        c.now_ms   = now;
        c.interval = ival;
        c.timer_id = tid;
        c.slot     = sl;
        cmd_backlog.push_back(c);
        plan_count++;
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || start || rsp_forecast.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic bit slot_fits(int i, slot_pick_t want);
        case (want)
            PICK_FREE:  return tbl_ident[i] == 32'd0;
            PICK_FIRED: return tbl_ident[i] != 32'd0 && tbl_pending[i];
            PICK_ARMED: return tbl_ident[i] != 32'd0 && !tbl_pending[i];
            default:    return tbl_ident[i] != 32'd0;
        endcase
    endfunction

    function automatic int pick_slot(slot_pick_t want);
        int count;
        int k;
        count = 0;
        for (int i = 0; i < ctt_pkg::SLOTS; i++)
        begin
            if (slot_fits(i, want))
            begin
                count++;
            end
        end
        if (count == 0)
        begin
            return -1;
        end
        k = $urandom_range(0, count - 1);
        for (int i = 0; i < ctt_pkg::SLOTS; i++)
        begin
            if (slot_fits(i, want))
            begin
                if (k == 0)
                begin
                    return i;
                end
                k--;
            end
        end
        return -1;
    endfunction

    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return $urandom_range(0, 60);
        end
        if (r < 9)
        begin
            return $urandom_range(0, 1000);
        end
        return $urandom;
    endfunction

    task automatic fill_table();
        repeat (ctt_pkg::SLOTS + 1)
        begin
            queue_cmd(ctt_pkg::OP_ADD, gen_now, $urandom_range(0, 30), $urandom,
                      5'($urandom));
        end
        gen_now = gen_now + 64'd100;
        queue_cmd(ctt_pkg::OP_SERVICE, gen_now, 32'd0, 32'd0, 5'd0);
    endtask

    task automatic plan_random_step();
        int          choice;
        int          s;
        logic [31:0] ival;
        logic [31:0] tid;
        choice = $urandom_range(0, 99);
        ival   = pick_interval();
        if (choice < 22 && pick_slot(PICK_FREE) < 0 && $urandom_range(0, 1) == 1)
        begin
            choice = 75;
        end
        if (choice < 22)
        begin
            queue_cmd(ctt_pkg::OP_ADD, gen_now, ival, 32'd0, 5'd0);
        end
        else if (choice < 47)
        begin
            gen_now = gen_now + 64'($urandom_range(0, 40));
            queue_cmd(ctt_pkg::OP_SERVICE, gen_now, 32'd0, 32'd0, 5'd0);
        end
        else if (choice < 72)
        begin
            s = pick_slot(choice < 65 ? PICK_FIRED : PICK_ARMED);
            if (s < 0)
            begin
                gen_now = gen_now + 64'($urandom_range(0, 40));
                queue_cmd(ctt_pkg::OP_SERVICE, gen_now, 32'd0, 32'd0, 5'd0);
            end
            else
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    ival = 32'd0;
                end
                queue_cmd(ctt_pkg::OP_REARM, gen_now, ival, tbl_ident[s], 5'(s));
            end
        end
        else if (choice < 82)
        begin
            s = pick_slot(PICK_LIVE);
            tid = (s < 0) ? 32'($urandom_range(1, 500)) : tbl_ident[s];
            queue_cmd(ctt_pkg::OP_REMOVE, gen_now, 32'd0, tid, 5'd0);
        end
        else if (choice < 90)
        begin
            tid = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
            queue_cmd(ctt_pkg::op_t'($urandom_range(0, 3)), {32'($urandom), 32'($urandom)},
                      $urandom, tid, 5'($urandom));
        end
        else if (choice < 95)
        begin
            s = pick_slot(PICK_LIVE);
            if (s < 0)
            begin
                queue_cmd(ctt_pkg::OP_REMOVE, gen_now, 32'd0, $urandom, 5'd0);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                queue_cmd(ctt_pkg::OP_REARM, gen_now, ival, tbl_ident[s],
                          5'(s) ^ 5'($urandom_range(1, 31)));
            end
            else
            begin
                queue_cmd(ctt_pkg::OP_REARM, gen_now, ival, tbl_ident[s] + 32'd1, 5'(s));
            end
        end
        else if (choice < 98)
        begin
            fill_table();
        end
        else
        begin
            wait_quiet();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(ctt_pkg::OP_ADD, 64'd100, 32'd0, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_ADD, 64'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(ctt_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 32'h20, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_SERVICE, 64'd100, 32'd0, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_SERVICE, 64'd100, 32'd0, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_REARM, 64'd200, 32'd5, 32'd1, 5'd0);
        queue_cmd(ctt_pkg::OP_REARM, 64'd200, 32'd0, 32'd3, 5'd2);
        queue_cmd(ctt_pkg::OP_REARM, 64'd300, 32'd7, 32'd2, 5'd1);
        queue_cmd(ctt_pkg::OP_REARM, 64'd300, 32'd7, 32'd0, 5'd1);
        queue_cmd(ctt_pkg::OP_REARM, 64'd300, 32'd9, 32'd99, 5'd5);
        queue_cmd(ctt_pkg::OP_REMOVE, 64'd0, 32'd0, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_REMOVE, 64'd0, 32'd0, 32'd12345, 5'd0);
        queue_cmd(ctt_pkg::OP_REMOVE, 64'd0, 32'd0, 32'd1, 5'd0);
        queue_cmd(ctt_pkg::OP_ADD, 64'd500, 32'd10, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_SERVICE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 5'd0);
        queue_cmd(ctt_pkg::OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                  5'd31);
        queue_cmd(ctt_pkg::OP_REARM, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 5'd31);
        queue_cmd(ctt_pkg::OP_REARM, 64'd0, 32'd0, 32'd4, 5'd0);
        queue_cmd(ctt_pkg::OP_SERVICE, 64'd0, 32'd0, 32'd0, 5'd0);

        wait_quiet();
        fill_table();
        while (plan_count < PLAN_ITEMS)
        begin
            @(negedge clk);
            while (cmd_backlog.size() != 0)
            begin
                @(negedge clk);
            end
            plan_random_step();
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && rsp_forecast.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_alu.sv
hw/rtl/callback_timer_table.sv
tb/tb_top.sv
